// ===== rtl/rrs_pkg.sv =====
package rrs_pkg;

  // default sizes of the slot table
  localparam int unsigned SLOTS_DEF   = 16;
  localparam int unsigned ID_BITS_DEF = 16;

  // fixed field widths on the channels
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned READY_W  = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SELECT = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NONE_RDY  = 2'd3
  } status_e;

  typedef struct packed {
    status_e              status;
    logic [ID_W-1:0]      granted_id;
    logic [SLOT_W-1:0]    slot_number;
    logic [COUNT_W-1:0]   occupied_count;
  } res_t;

endpackage

// ===== rtl/rrs_cmd_if.sv =====
interface rrs_cmd_if import rrs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [ID_W-1:0]    stream_id;
  logic [READY_W-1:0] ready_mask;

  modport source (output valid, output command, output stream_id, output ready_mask,
                  input ready);
  modport sink   (input valid, input command, input stream_id, input ready_mask,
                  output ready);
endinterface

// ===== rtl/rrs_res_if.sv =====
interface rrs_res_if import rrs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     granted_id;
  logic [SLOT_W-1:0]   slot_number;
  logic [COUNT_W-1:0]  occupied_count;

  modport source (output valid, output status, output granted_id, output slot_number,
                  output occupied_count, input ready);
  modport sink   (input valid, input status, input granted_id, input slot_number,
                  input occupied_count, output ready);
endinterface

// ===== rtl/round_robin_ready_selector.sv =====
// Slot table with round robin grant. Every command transfer on cmd_i (insert,
// remove, select) produces exactly one result transfer on res_o. A command is
// taken every cycle unless both result entries are held: the first-free search,
// the parallel id compare over all slots and the rotating priority encoder sit
// in combinational logic between the command port and the result buffer, which
// registers the result on the command transfer. A two-entry result buffer lets
// the next command in while one result waits; cmd_i.ready drops only when both
// entries are held. Ids are kept in their low ID_BITS bits, duplicate ids are
// allowed (remove frees the lowest matching slot), only slots below 16 can be
// granted, and only the valid bits, count and last grant are cleared at reset.
module round_robin_ready_selector import rrs_pkg::*; #(
  parameter int unsigned SLOTS   = SLOTS_DEF,
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rrs_cmd_if.sink   cmd_i,
  rrs_res_if.source res_o
);

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  // stored id bits: the port carries ID_W bits, anything above is always zero
  localparam int unsigned KEEP_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;

  // lowest set bit, msb of the result flags a hit
  function automatic logic [IDX_W:0] first_set(input logic [SLOTS-1:0] v);
    logic [IDX_W:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, IDX_W'(i)};
      end
    end
    return r;
  endfunction

  // slot table state
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [KEEP_W-1:0] slot_id_q [SLOTS];
  logic [CNT_W-1:0]  used_q, used_d;
  logic [IDX_W-1:0]  last_q, last_d;

  // result buffer: head drives res_o, skid catches a result while head stalls
  res_t head_q, skid_q, res_d;
  logic head_vld_q, skid_vld_q;

  logic push, pop;
  assign cmd_i.ready = !skid_vld_q;
  assign push = cmd_i.valid && cmd_i.ready;
  assign pop  = res_o.valid && res_o.ready;

  // per-slot search vectors
  logic [KEEP_W-1:0]          id_in;
  logic [SLOTS+READY_W-1:0]   rdy_ext;
  logic [SLOTS-1:0]           elig, elig_hi, match;
  logic [IDX_W-1:0]           start_idx;
  logic [IDX_W:0]             free_hit, match_hit, hi_hit, any_hit, grant_hit;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_idx;

  assign id_in   = cmd_i.stream_id[KEEP_W-1:0];
  // slots at or above the mask width are never ready
  assign rdy_ext = {{SLOTS{1'b0}}, cmd_i.ready_mask};
  // scan starts just after the last grant and wraps
  assign start_idx = (last_q == IDX_W'(SLOTS - 1)) ? '0 : last_q + 1'b1;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      elig[i]    = valid_q[i] && rdy_ext[i];
      elig_hi[i] = elig[i] && (IDX_W'(i) >= start_idx);
      match[i]   = valid_q[i] && (slot_id_q[i] == id_in);
    end
  end

  assign free_hit  = first_set(~valid_q);
  assign match_hit = first_set(match);
  assign hi_hit    = first_set(elig_hi);
  assign any_hit   = first_set(elig);
  // upper part of the rotation first, otherwise wrap to the bottom
  assign grant_hit = hi_hit[IDX_W] ? hi_hit : any_hit;

  // width adapters to the fixed output fields
  logic [IDX_W+SLOT_W-1:0]  slot_ext;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;
  logic [KEEP_W+ID_W-1:0]   gid_ext;
  logic [IDX_W-1:0]         slot_sel;

  assign cnt_ext = {{COUNT_W{1'b0}}, used_d};
  assign slot_ext = {{SLOT_W{1'b0}}, slot_sel};
  assign gid_ext = {{ID_W{1'b0}}, slot_id_q[grant_hit[IDX_W-1:0]]};

  always_comb begin
    valid_d  = valid_q;
    used_d   = used_q;
    last_d   = last_q;
    wr_en    = 1'b0;
    wr_idx   = free_hit[IDX_W-1:0];
    slot_sel = '0;
    res_d.status     = ST_OK;
    res_d.granted_id = '0;
    case (cmd_e'(cmd_i.command))
      CMD_INSERT: begin
        if (free_hit[IDX_W]) begin
          valid_d[free_hit[IDX_W-1:0]] = 1'b1;
          used_d   = used_q + 1'b1;
          wr_en    = 1'b1;
          slot_sel = free_hit[IDX_W-1:0];
        end else begin
          res_d.status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (match_hit[IDX_W]) begin
          valid_d[match_hit[IDX_W-1:0]] = 1'b0;
          used_d = used_q - 1'b1;
        end else begin
          res_d.status = ST_NOT_FOUND;
        end
      end
      CMD_SELECT: begin
        if (grant_hit[IDX_W]) begin
          last_d           = grant_hit[IDX_W-1:0];
          slot_sel         = grant_hit[IDX_W-1:0];
          res_d.granted_id = gid_ext[ID_W-1:0];
        end else begin
          res_d.status = ST_NONE_RDY;
        end
      end
      default: begin
        // unused command code: no change, plain ok result
      end
    endcase
    res_d.slot_number    = slot_ext[SLOT_W-1:0];
    res_d.occupied_count = cnt_ext[COUNT_W-1:0];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      last_q  <= '0;
    end else if (push) begin
      valid_q <= valid_d;
      used_q  <= used_d;
      last_q  <= last_d;
    end
  end

  // id storage, undefined until written
  always_ff @(posedge clk_i) begin
    if (push && wr_en) begin
      slot_id_q[wr_idx] <= id_in;
    end
  end

  // result buffer flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        head_vld_q <= push;
      end
    end else if (push) begin
      if (head_vld_q) begin
        skid_vld_q <= 1'b1;
      end else begin
        head_vld_q <= 1'b1;
      end
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_vld_q) begin
        head_q <= skid_q;
      end else if (push) begin
        head_q <= res_d;
      end
    end else if (push) begin
      if (head_vld_q) begin
        skid_q <= res_d;
      end else begin
        head_q <= res_d;
      end
    end
  end

  assign res_o.valid          = head_vld_q;
  assign res_o.status         = head_q.status;
  assign res_o.granted_id     = head_q.granted_id;
  assign res_o.slot_number    = head_q.slot_number;
  assign res_o.occupied_count = head_q.occupied_count;

  // count tracks the occupied slots
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) == $countones(valid_q))
    else $error("occupied count out of step with valid bits");

  // skid entry only ever sits behind a held head
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> head_vld_q)
    else $error("skid entry held without head entry");

  // a granted slot is occupied and was ready
  a_grant_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && cmd_i.command == CMD_SELECT && grant_hit[IDX_W])
      |-> (valid_q[grant_hit[IDX_W-1:0]] && rdy_ext[grant_hit[IDX_W-1:0]]))
    else $error("grant to a slot that is not occupied and ready");

  // a grant is recorded as the last grant
  a_grant_recorded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && cmd_i.command == CMD_SELECT && grant_hit[IDX_W])
      |=> (last_q == $past(grant_hit[IDX_W-1:0])))
    else $error("last grant not updated");

endmodule
